### rtl/mes_pkg.sv
package mes_pkg;

  // Longest event: status plus four controller pairs
  localparam int unsigned MaxBytes   = 9;
  localparam int unsigned DataBytes  = MaxBytes - 1;
  localparam int unsigned LenW       = $clog2(MaxBytes + 1);
  // Job queue depth, a power of two
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  typedef enum logic [4:0] {
    CMD_KEY_ON      = 5'd0,
    CMD_KEY_OFF     = 5'd1,
    CMD_POLY_PRESS  = 5'd2,
    CMD_CTRL        = 5'd3,
    CMD_PROGRAM     = 5'd4,
    CMD_CHAN_PRESS  = 5'd5,
    CMD_PITCH_WHEEL = 5'd6,
    CMD_SONG_POS    = 5'd7,
    CMD_SONG_SEL    = 5'd8,
    CMD_CLOCK       = 5'd9,
    CMD_START       = 5'd10,
    CMD_CONTINUE    = 5'd11,
    CMD_STOP        = 5'd12,
    CMD_TUNE        = 5'd13,
    CMD_ACTIVE      = 5'd14,
    CMD_RESET       = 5'd15,
    CMD_QFRAME      = 5'd16,
    CMD_CTRL14      = 5'd17,
    CMD_NRPN        = 5'd18,
    CMD_RPN         = 5'd19,
    CMD_NOTE        = 5'd20,
    CMD_IGNORED     = 5'd21
  } cmd_e;

  localparam logic [7:0] StNoteOff   = 8'h80;
  localparam logic [7:0] StNoteOn    = 8'h90;
  localparam logic [7:0] StPoly      = 8'hA0;
  localparam logic [7:0] StControl   = 8'hB0;
  localparam logic [7:0] StProgram   = 8'hC0;
  localparam logic [7:0] StChanPress = 8'hD0;
  localparam logic [7:0] StPitch     = 8'hE0;
  localparam logic [7:0] StQFrame    = 8'hF1;
  localparam logic [7:0] StSongPos   = 8'hF2;
  localparam logic [7:0] StSongSel   = 8'hF3;
  localparam logic [7:0] StTune      = 8'hF6;
  localparam logic [7:0] StClock     = 8'hF8;
  localparam logic [7:0] StStart     = 8'hFA;
  localparam logic [7:0] StContinue  = 8'hFB;
  localparam logic [7:0] StStop      = 8'hFC;
  localparam logic [7:0] StActive    = 8'hFE;
  localparam logic [7:0] StReset     = 8'hFF;
  localparam logic [7:0] StNone      = 8'h00;

  localparam logic [6:0] NrpnMsb  = 7'd99;
  localparam logic [6:0] NrpnLsb  = 7'd98;
  localparam logic [6:0] RpnMsb   = 7'd101;
  localparam logic [6:0] RpnLsb   = 7'd100;
  localparam logic [6:0] EntryMsb = 7'd6;
  localparam logic [6:0] EntryLsb = 7'd38;

  typedef struct packed {
    logic [4:0]  command;
    logic [3:0]  channel;
    logic [6:0]  first_data;
    logic [6:0]  second_data;
    logic [13:0] param_number;
    logic [13:0] param_value;
  } evt_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } out_t;

  // Wire bytes of one event, first byte in entry 0
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [LenW-1:0]          len;
  } job_t;

endpackage

### rtl/mes_front.sv
module mes_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mes_pkg::evt_t     in_data_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output mes_pkg::job_t     push_job_o
);

  logic [7:0] run_st_q, run_st_d;
  logic [7:0] st;
  logic       chan_msg;
  logic       sys_msg;
  logic       clr_run;
  logic       emit_st;
  logic [mes_pkg::DataBytes-1:0][6:0] dat;
  logic [mes_pkg::LenW-1:0] ndat;
  logic       in_xfer;
  logic [6:0] num5;

  assign in_ready_o = push_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign num5       = {2'b00, in_data_i.param_number[4:0]};

  always_comb begin
    st       = mes_pkg::StNone;
    chan_msg = 1'b0;
    sys_msg  = 1'b0;
    clr_run  = 1'b0;
    dat      = '0;
    ndat     = '0;
    case (in_data_i.command)
      mes_pkg::CMD_KEY_ON, mes_pkg::CMD_NOTE, mes_pkg::CMD_KEY_OFF,
      mes_pkg::CMD_POLY_PRESS, mes_pkg::CMD_CTRL, mes_pkg::CMD_PITCH_WHEEL: begin
        chan_msg = 1'b1;
        dat[0]   = in_data_i.first_data;
        dat[1]   = in_data_i.second_data;
        ndat     = mes_pkg::LenW'(2);
        case (in_data_i.command)
          mes_pkg::CMD_KEY_OFF:     st = mes_pkg::StNoteOff;
          mes_pkg::CMD_POLY_PRESS:  st = mes_pkg::StPoly;
          mes_pkg::CMD_CTRL:        st = mes_pkg::StControl;
          mes_pkg::CMD_PITCH_WHEEL: st = mes_pkg::StPitch;
          default:                  st = mes_pkg::StNoteOn;
        endcase
        st[3:0] = in_data_i.channel;
      end
      mes_pkg::CMD_PROGRAM, mes_pkg::CMD_CHAN_PRESS: begin
        chan_msg = 1'b1;
        st       = (in_data_i.command == mes_pkg::CMD_PROGRAM) ?
                   mes_pkg::StProgram : mes_pkg::StChanPress;
        st[3:0]  = in_data_i.channel;
        dat[0]   = in_data_i.first_data;
        ndat     = mes_pkg::LenW'(1);
      end
      mes_pkg::CMD_SONG_POS: begin
        sys_msg = 1'b1;
        clr_run = 1'b1;
        st      = mes_pkg::StSongPos;
        dat[0]  = in_data_i.first_data;
        dat[1]  = in_data_i.second_data;
        ndat    = mes_pkg::LenW'(2);
      end
      mes_pkg::CMD_SONG_SEL: begin
        sys_msg = 1'b1;
        clr_run = 1'b1;
        st      = mes_pkg::StSongSel;
        dat[0]  = in_data_i.first_data;
        ndat    = mes_pkg::LenW'(1);
      end
      mes_pkg::CMD_QFRAME: begin
        sys_msg = 1'b1;
        clr_run = 1'b1;
        st      = mes_pkg::StQFrame;
        dat[0]  = {in_data_i.first_data[2:0], in_data_i.second_data[3:0]};
        ndat    = mes_pkg::LenW'(1);
      end
      mes_pkg::CMD_CLOCK:    begin sys_msg = 1'b1; st = mes_pkg::StClock;    end
      mes_pkg::CMD_START:    begin sys_msg = 1'b1; st = mes_pkg::StStart;    end
      mes_pkg::CMD_CONTINUE: begin sys_msg = 1'b1; st = mes_pkg::StContinue; end
      mes_pkg::CMD_STOP:     begin sys_msg = 1'b1; st = mes_pkg::StStop;     end
      mes_pkg::CMD_TUNE:     begin sys_msg = 1'b1; st = mes_pkg::StTune;     end
      mes_pkg::CMD_ACTIVE:   begin sys_msg = 1'b1; st = mes_pkg::StActive;   end
      mes_pkg::CMD_RESET:    begin sys_msg = 1'b1; st = mes_pkg::StReset;    end
      mes_pkg::CMD_CTRL14: begin
        chan_msg = 1'b1;
        st       = mes_pkg::StControl;
        st[3:0]  = in_data_i.channel;
        dat[0]   = num5;
        dat[1]   = in_data_i.param_value[13:7];
        dat[2]   = {2'b01, in_data_i.param_number[4:0]};  // number + 32
        dat[3]   = in_data_i.param_value[6:0];
        ndat     = mes_pkg::LenW'(4);
      end
      mes_pkg::CMD_NRPN, mes_pkg::CMD_RPN: begin
        chan_msg = 1'b1;
        st       = mes_pkg::StControl;
        st[3:0]  = in_data_i.channel;
        dat[0]   = (in_data_i.command == mes_pkg::CMD_NRPN) ?
                   mes_pkg::NrpnMsb : mes_pkg::RpnMsb;
        dat[1]   = in_data_i.param_number[13:7];
        dat[2]   = (in_data_i.command == mes_pkg::CMD_NRPN) ?
                   mes_pkg::NrpnLsb : mes_pkg::RpnLsb;
        dat[3]   = in_data_i.param_number[6:0];
        dat[4]   = mes_pkg::EntryMsb;
        dat[5]   = in_data_i.param_value[13:7];
        dat[6]   = mes_pkg::EntryLsb;
        dat[7]   = in_data_i.param_value[6:0];
        ndat     = mes_pkg::LenW'(8);
      end
      default: begin
      end
    endcase
  end

  // Status is dropped only for a channel message matching running status
  assign emit_st = sys_msg || (chan_msg && (st != run_st_q));

  always_comb begin
    push_job_o.bytes = '0;
    if (emit_st) begin
      push_job_o.bytes[0] = st;
      for (int i = 0; i < mes_pkg::DataBytes; i++) begin
        push_job_o.bytes[i+1] = {1'b0, dat[i]};
      end
    end else begin
      for (int i = 0; i < mes_pkg::DataBytes; i++) begin
        push_job_o.bytes[i] = {1'b0, dat[i]};
      end
    end
    push_job_o.len = ndat + mes_pkg::LenW'(emit_st);
  end

  // Events that produce no bytes are taken and dropped here
  assign push_valid_o = in_valid_i && (push_job_o.len != '0);

  always_comb begin
    run_st_d = run_st_q;
    if (in_xfer) begin
      if (chan_msg) begin
        run_st_d = st;
      end else if (clr_run) begin
        run_st_d = mes_pkg::StNone;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_st_q <= mes_pkg::StNone;
    end else begin
      run_st_q <= run_st_d;
    end
  end

endmodule

### rtl/mes_queue.sv
module mes_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  mes_pkg::job_t push_job_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output mes_pkg::job_t pop_job_o
);

  mes_pkg::job_t mem_q [mes_pkg::QueueDepth];
  logic [mes_pkg::QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [mes_pkg::QCntW-1:0] cnt_q, cnt_d;
  logic push, pop;

  assign push_ready_o = (cnt_q != mes_pkg::QCntW'(mes_pkg::QueueDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_job_o    = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + mes_pkg::QCntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - mes_pkg::QCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + mes_pkg::QPtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + mes_pkg::QPtrW'(1);
      end
    end
  end

endmodule

### rtl/mes_back.sv
module mes_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          pop_valid_i,
  output logic          pop_ready_o,
  input  mes_pkg::job_t pop_job_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output mes_pkg::out_t out_data_o
);

  logic [mes_pkg::MaxBytes-1:0][7:0] bytes_q, bytes_d;
  logic [mes_pkg::LenW-1:0]          cnt_q, cnt_d;
  logic last, out_xfer, load;

  assign last        = (cnt_q == mes_pkg::LenW'(1));
  assign out_valid_o = (cnt_q != '0);
  assign out_xfer    = out_valid_o && out_ready_i;
  // Next job loads as the final byte of the current one transfers
  assign pop_ready_o = !out_valid_o || (out_xfer && last);
  assign load        = pop_valid_i && pop_ready_o;

  assign out_data_o.out_byte  = bytes_q[0];
  assign out_data_o.last_byte = last;

  always_comb begin
    bytes_d = bytes_q;
    cnt_d   = cnt_q;
    if (load) begin
      bytes_d = pop_job_i.bytes;
      cnt_d   = pop_job_i.len;
    end else if (out_xfer) begin
      for (int i = 0; i < mes_pkg::MaxBytes - 1; i++) begin
        bytes_d[i] = bytes_q[i+1];
      end
      bytes_d[mes_pkg::MaxBytes-1] = '0;
      cnt_d = cnt_q - mes_pkg::LenW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

### rtl/midi_event_serializer.sv
// MIDI event serializer: takes one event per transfer and sends its wire bytes,
// one byte per output transfer, with last_byte set on the final byte of each
// event. Each wire byte is one output transfer: 1 byte for real-time
// and tune, up to 3 for short messages, up to 5 for a 14-bit controller and up
// to 9 for NRPN or RPN (one less when running status drops the status byte);
// the output shifter sends one byte per cycle while out_ready_i is high.
// Channel messages omit their status byte when it equals running status.
// Events are classified on arrival and held in a two-entry job queue, so input
// is taken while earlier bytes are still going out; events with no bytes are
// taken and dropped. Output data and valid come straight from registers.
module midi_event_serializer (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  mes_pkg::evt_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output mes_pkg::out_t out_data_o
);

  logic          push_valid, push_ready;
  mes_pkg::job_t push_job;
  logic          pop_valid, pop_ready;
  mes_pkg::job_t pop_job;

  mes_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_job_o   (push_job)
  );

  mes_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_job_o    (pop_job)
  );

  mes_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_job_i   (pop_job),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
